// File: design/assert_macros.svh
// Assertion helpers, clocked on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: design/ldtw_pkg.sv
package ldtw_pkg;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_DIGITS = 2'd3
  } kind_e;

  localparam logic [7:0] ADDR_CMD   = 8'hC0;
  localparam logic [7:0] COLON_SET  = 8'h80;
  localparam logic [7:0] COLON_CLR  = 8'h7F;
  localparam logic [7:0] LSB_MASK   = 8'h01;
  localparam logic [7:0] HALF_RESET = 8'd2;
  localparam int unsigned QueueDepth = 8;
  localparam int unsigned NumDigits  = 4;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] command_byte;
    logic [2:0] digit_address;
    logic [7:0] data_byte;
    logic [7:0] digit_zero;
    logic [7:0] digit_one;
    logic [7:0] digit_two;
    logic [7:0] digit_three;
    logic       colon_on;
  } in_word_t;

  typedef struct packed {
    logic clock_line;
    logic data_line;
    logic data_drive;
    logic busy_res;
    logic request_dropped;
  } out_word_t;

endpackage

// File: design/ldtw_in_if.sv
interface ldtw_in_if;
  logic               valid;
  logic               ready;
  ldtw_pkg::in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// File: design/ldtw_out_if.sv
interface ldtw_out_if;
  logic                valid;
  logic                ready;
  ldtw_pkg::out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// File: design/led_driver_two_wire_writer.sv
// Two-wire LED driver writer. Each input word is one tick: kind 0 just advances the
// sequencer, kinds 1..3 start a command, address/data or four-digit transfer when idle
// (and are dropped and flagged when busy). Every input word gives exactly one output
// word with the wire levels after that tick. One word per cycle: the whole tick update
// sits between the sequencer registers and the result register, and a new word is taken
// whenever the result register is empty or being read in the same cycle.
// cfg_data_i sets the ticks waited after every wire change (0 acts as 1).
`include "assert_macros.svh"

module led_driver_two_wire_writer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  ldtw_in_if.sink    in_i,
  ldtw_out_if.source out_o
);

  typedef enum logic [4:0] {
    P_IDLE   = 5'd0,
    P_START1 = 5'd1,
    P_START2 = 5'd2,
    P_START3 = 5'd3,
    P_START4 = 5'd4,
    P_BIT1   = 5'd5,
    P_BIT2   = 5'd6,
    P_BIT3   = 5'd7,
    P_ACK1   = 5'd8,
    P_ACK2   = 5'd9,
    P_ACK3   = 5'd10,
    P_ACK4   = 5'd11,
    P_ACK5   = 5'd12,
    P_ACK6   = 5'd13,
    P_STOP1  = 5'd14,
    P_STOP2  = 5'd15,
    P_STOP3  = 5'd16
  } phase_e;

  localparam int unsigned QW = $clog2(ldtw_pkg::QueueDepth);
  localparam int unsigned DW = $clog2(ldtw_pkg::NumDigits);

  phase_e              phase_q, phase_d, next_phase;
  logic [7:0]          half_q, wait_q, wait_d, wait_dec;
  logic [7:0]          shift_q, shift_d;
  logic [2:0]          bit_q, bit_d, bit_inc;
  logic [QW-1:0]       frame_q, frame_d, frame_inc;
  logic [3:0]          left_q, left_d, left_dec;
  logic                pair_q, pair_d;
  logic                clock_q, clock_d, data_q, data_d, drive_q, drive_d;
  logic [7:0]          queue_q [ldtw_pkg::QueueDepth];
  logic [7:0]          queue_d [ldtw_pkg::QueueDepth];
  logic [7:0]          digits [ldtw_pkg::NumDigits];
  logic                enter, dropped, in_fire, out_valid_q, out_valid_d;
  ldtw_pkg::out_word_t out_q, out_d;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_q;

  assign digits[0] = in_i.word.digit_zero;
  assign digits[1] = in_i.word.colon_on ? (in_i.word.digit_one | ldtw_pkg::COLON_SET)
                                        : (in_i.word.digit_one & ldtw_pkg::COLON_CLR);
  assign digits[2] = in_i.word.digit_two;
  assign digits[3] = in_i.word.digit_three;

  assign wait_dec  = wait_q - {7'd0, (wait_q != 8'd0)};
  assign bit_inc   = bit_q + 3'd1;
  assign frame_inc = frame_q + {{(QW-1){1'b0}}, 1'b1};
  assign left_dec  = left_q - {3'd0, (left_q != 4'd0)};

  always_comb begin
    phase_d    = phase_q;
    wait_d     = wait_q;
    shift_d    = shift_q;
    bit_d      = bit_q;
    frame_d    = frame_q;
    left_d     = left_q;
    pair_d     = pair_q;
    clock_d    = clock_q;
    data_d     = data_q;
    drive_d    = drive_q;
    queue_d    = queue_q;
    next_phase = phase_q;
    enter      = 1'b0;
    dropped    = 1'b0;

    if (in_fire) begin
      if (phase_q != P_IDLE) begin
        dropped = (in_i.word.kind != ldtw_pkg::KIND_TICK);
        wait_d  = wait_dec;
        if (wait_dec == 8'd0) begin
          case (phase_q)
            P_START4: begin
              shift_d    = queue_q[frame_q];
              bit_d      = 3'd0;
              next_phase = P_BIT1;
              enter      = 1'b1;
            end
            P_BIT3: begin
              shift_d    = shift_q >> 1;
              bit_d      = bit_inc;
              next_phase = (bit_inc == 3'd0) ? P_ACK1 : P_BIT1;
              enter      = 1'b1;
            end
            P_ACK6: begin
              frame_d = frame_inc;
              left_d  = left_dec;
              enter   = 1'b1;
              if (left_dec != 4'd0 && pair_q && frame_inc[0]) begin
                shift_d    = queue_q[frame_inc];
                bit_d      = 3'd0;
                next_phase = P_BIT1;
              end else begin
                next_phase = P_STOP1;
              end
            end
            P_STOP3: begin
              if (left_q != 4'd0) begin
                next_phase = P_START1;
                enter      = 1'b1;
              end else begin
                phase_d = P_IDLE;
                wait_d  = 8'd0;
              end
            end
            default: begin
              next_phase = phase_e'(phase_q + 5'd1);
              enter      = 1'b1;
            end
          endcase
        end
      end else if (in_i.word.kind != ldtw_pkg::KIND_TICK) begin
        frame_d    = '0;
        next_phase = P_START1;
        enter      = 1'b1;
        case (in_i.word.kind)
          ldtw_pkg::KIND_CMD: begin
            queue_d[0] = in_i.word.command_byte;
            left_d     = 4'd1;
            pair_d     = 1'b0;
          end
          ldtw_pkg::KIND_DATA: begin
            queue_d[0] = ldtw_pkg::ADDR_CMD | {5'd0, in_i.word.digit_address};
            queue_d[1] = in_i.word.data_byte;
            left_d     = 4'd2;
            pair_d     = 1'b1;
          end
          default: begin
            for (int a = 0; a < ldtw_pkg::NumDigits; a++) begin
              queue_d[QW'(2*a)]   = ldtw_pkg::ADDR_CMD | 8'(a);
              queue_d[QW'(2*a+1)] = digits[DW'(a)];
            end
            left_d = 4'(2 * ldtw_pkg::NumDigits);
            pair_d = 1'b1;
          end
        endcase
      end
    end

    if (enter) begin
      phase_d = next_phase;
      wait_d  = (half_q != 8'd0) ? half_q : 8'd1;
      case (next_phase)
        P_START1: data_d  = 1'b1;
        P_START2: clock_d = 1'b1;
        P_START3: data_d  = 1'b0;
        P_START4: clock_d = 1'b0;
        P_BIT1:   clock_d = 1'b0;
        P_BIT2:   data_d  = |(shift_d & ldtw_pkg::LSB_MASK);
        P_BIT3:   clock_d = 1'b1;
        P_ACK1:   clock_d = 1'b0;
        P_ACK2:   drive_d = 1'b0;
        P_ACK3:   clock_d = 1'b1;
        P_ACK5:   clock_d = 1'b0;
        P_ACK6:   drive_d = 1'b1;
        P_STOP1:  data_d  = 1'b0;
        P_STOP2:  clock_d = 1'b1;
        P_STOP3:  data_d  = 1'b1;
        default: ;
      endcase
    end

    out_d.clock_line      = clock_d;
    out_d.data_line       = data_d;
    out_d.data_drive      = drive_d;
    out_d.busy_res        = (phase_d != P_IDLE);
    out_d.request_dropped = dropped;
    out_valid_d = in_fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= P_IDLE;
      half_q      <= ldtw_pkg::HALF_RESET;
      wait_q      <= 8'd0;
      shift_q     <= 8'd0;
      bit_q       <= 3'd0;
      frame_q     <= '0;
      left_q      <= 4'd0;
      pair_q      <= 1'b0;
      clock_q     <= 1'b0;
      data_q      <= 1'b0;
      drive_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      if (cfg_we_i) begin
        half_q <= cfg_data_i;
      end
      wait_q      <= wait_d;
      shift_q     <= shift_d;
      bit_q       <= bit_d;
      frame_q     <= frame_d;
      left_q      <= left_d;
      pair_q      <= pair_d;
      clock_q     <= clock_d;
      data_q      <= data_d;
      drive_q     <= drive_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload only: queue and result word
  always_ff @(posedge clk_i) begin
    queue_q <= queue_d;
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  `ASSERT_NEVER(busy_wait_nonzero, phase_q != P_IDLE && wait_q == 8'd0,
                "busy sequencer with empty wait count")
  `ASSERT_NEVER(idle_released, phase_q == P_IDLE && !drive_q,
                "data wire released while idle")
  `ASSERT_AT(drop_flagged,
             in_fire && phase_q != P_IDLE && in_i.word.kind != ldtw_pkg::KIND_TICK
               |=> out_q.request_dropped,
             "request while busy not flagged")
  `ASSERT_AT(start_busy,
             in_fire && phase_q == P_IDLE && in_i.word.kind != ldtw_pkg::KIND_TICK
               |=> phase_q == P_START1 && data_q,
             "request while idle did not start a frame")

endmodule

// File: verif/led_driver_two_wire_writer_tb.sv
module led_driver_two_wire_writer_tb;

  typedef enum int unsigned {
    ST_IDLE,
    ST_START_DH, ST_START_CH, ST_START_DL, ST_START_CL,
    ST_BIT_CL, ST_BIT_DATA, ST_BIT_CH,
    ST_ACK_CL, ST_ACK_REL, ST_ACK_CH, ST_ACK_HOLD, ST_ACK_CL2, ST_ACK_DRIVE,
    ST_STOP_DL, ST_STOP_CH, ST_STOP_DH
  } wire_step_e;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_data_i;

  ldtw_in_if  in_if ();
  ldtw_out_if out_if ();

  led_driver_two_wire_writer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // wire sequencer state as the block should hold it
  logic [7:0]  half_ticks = ldtw_pkg::HALF_RESET;
  wire_step_e  step       = ST_IDLE;
  logic [7:0]  wait_left  = '0;
  logic [7:0]  shreg      = '0;
  logic [2:0]  bit_idx    = '0;
  logic [2:0]  frame_ptr  = '0;
  logic [7:0]  byte_fifo [ldtw_pkg::QueueDepth] = '{default: '0};
  logic        scl        = 1'b0;
  logic        sda        = 1'b0;
  logic        sda_oe     = 1'b1;
  int unsigned bytes_owed = 0;
  bit          paired     = 1'b0;

  ldtw_pkg::out_word_t levels_due [$];
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches    = 0;
  bit          stalls_on     = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void enter_step(wire_step_e s);
    step      = s;
    wait_left = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
    case (s)
      ST_START_DH, ST_STOP_DH: sda = 1'b1;
      ST_START_DL, ST_STOP_DL: sda = 1'b0;
      ST_START_CH, ST_BIT_CH, ST_ACK_CH, ST_STOP_CH: scl = 1'b1;
      ST_START_CL, ST_BIT_CL, ST_ACK_CL, ST_ACK_CL2: scl = 1'b0;
      ST_BIT_DATA: sda = (shreg & ldtw_pkg::LSB_MASK) != 8'd0;
      ST_ACK_REL: sda_oe = 1'b0;
      ST_ACK_DRIVE: sda_oe = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic void load_next_byte();
    shreg   = byte_fifo[frame_ptr];
    bit_idx = '0;
    enter_step(ST_BIT_CL);
  endfunction

  function automatic void next_step();
    case (step)
      ST_START_CL: load_next_byte();
      ST_BIT_CH: begin
        shreg   = shreg >> 1;
        bit_idx = bit_idx + 3'd1;
        enter_step(bit_idx == 3'd0 ? ST_ACK_CL : ST_BIT_CL);
      end
      ST_ACK_DRIVE: begin
        frame_ptr = frame_ptr + 3'd1;
        if (bytes_owed > 0) bytes_owed--;
        if (bytes_owed > 0 && paired && frame_ptr[0]) load_next_byte();
        else enter_step(ST_STOP_DL);
      end
      ST_STOP_DH: begin
        if (bytes_owed > 0) begin
          enter_step(ST_START_DH);
        end else begin
          step      = ST_IDLE;
          wait_left = '0;
        end
      end
      default: enter_step(wire_step_e'(step + 1));
    endcase
  endfunction

  // levels on the wires after the tick that this word makes
  function automatic ldtw_pkg::out_word_t wire_levels_after(ldtw_pkg::in_word_t w);
    ldtw_pkg::out_word_t lv;
    logic                drop;
    drop = 1'b0;
    if (step != ST_IDLE) begin
      if (w.kind != ldtw_pkg::KIND_TICK) drop = 1'b1;
      if (wait_left > 0) wait_left--;
      if (wait_left == 0) next_step();
    end else if (w.kind != ldtw_pkg::KIND_TICK) begin
      frame_ptr = '0;
      case (w.kind)
        ldtw_pkg::KIND_CMD: begin
          byte_fifo[0] = w.command_byte;
          bytes_owed   = 1;
          paired       = 1'b0;
        end
        ldtw_pkg::KIND_DATA: begin
          byte_fifo[0] = ldtw_pkg::ADDR_CMD | {5'd0, w.digit_address};
          byte_fifo[1] = w.data_byte;
          bytes_owed   = 2;
          paired       = 1'b1;
        end
        default: begin
          for (int a = 0; a < ldtw_pkg::NumDigits; a++)
            byte_fifo[3'(2 * a)] = ldtw_pkg::ADDR_CMD | 8'(a);
          byte_fifo[1] = w.digit_zero;
          byte_fifo[3] = w.colon_on ? (w.digit_one | ldtw_pkg::COLON_SET)
                                    : (w.digit_one & ldtw_pkg::COLON_CLR);
          byte_fifo[5] = w.digit_two;
          byte_fifo[7] = w.digit_three;
          bytes_owed   = 8;
          paired       = 1'b1;
        end
      endcase
      enter_step(ST_START_DH);
    end
    lv.clock_line      = scl;
    lv.data_line       = sda;
    lv.data_drive      = sda_oe;
    lv.busy_res        = step != ST_IDLE;
    lv.request_dropped = drop;
    return lv;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    if (mismatches < 40)
      $display("word %0d: %s got %0b want %0b", words_checked, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : levels_checker
    ldtw_pkg::out_word_t due;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (levels_due.size() == 0) begin
        report_mismatch("word with none due, busy", out_if.word.busy_res, 1'b0);
      end else begin
        due = levels_due.pop_front();
        if (out_if.word.clock_line !== due.clock_line)
          report_mismatch("clock_line", out_if.word.clock_line, due.clock_line);
        if (out_if.word.data_line !== due.data_line)
          report_mismatch("data_line", out_if.word.data_line, due.data_line);
        if (out_if.word.data_drive !== due.data_drive)
          report_mismatch("data_drive", out_if.word.data_drive, due.data_drive);
        if (out_if.word.busy_res !== due.busy_res)
          report_mismatch("busy_res", out_if.word.busy_res, due.busy_res);
        if (out_if.word.request_dropped !== due.request_dropped)
          report_mismatch("request_dropped", out_if.word.request_dropped,
                          due.request_dropped);
      end
      words_checked++;
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stalls_on && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // returns at the accepting edge with valid still high
  task automatic send_word(ldtw_pkg::in_word_t w);
    if (stalls_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.word  <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    levels_due.push_back(wire_levels_after(w));
    words_sent++;
  endtask

  task automatic hold_input();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_half_phase(logic [7:0] ticks);
    hold_input();
    while (levels_due.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= ticks;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    half_ticks = ticks;
  endtask

  function automatic ldtw_pkg::in_word_t random_word(ldtw_pkg::kind_e k);
    ldtw_pkg::in_word_t w;
    logic [63:0]        r;
    r = {$urandom, $urandom};
    w = r[$bits(ldtw_pkg::in_word_t)-1:0];
    w.kind = k;
    return w;
  endfunction

  function automatic ldtw_pkg::kind_e random_request();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 10) return ldtw_pkg::KIND_CMD;
    if (r < 17) return ldtw_pkg::KIND_DATA;
    return ldtw_pkg::KIND_DIGITS;
  endfunction

  // tick until the transfer is over, now and then throwing in a request
  task automatic tick_until_idle(int unsigned drop_pct);
    while (step != ST_IDLE) begin
      if ($urandom_range(0, 99) < drop_pct) send_word(random_word(random_request()));
      else send_word(random_word(ldtw_pkg::KIND_TICK));
    end
  endtask

  task automatic test_idle_ticks();
    repeat (3) send_word(random_word(ldtw_pkg::KIND_TICK));
  endtask

  task automatic test_command_frames();
    ldtw_pkg::in_word_t w;
    w = '0;
    w.kind = ldtw_pkg::KIND_CMD;
    send_word(w);
    tick_until_idle(0);
    set_half_phase(8'd1);
    w = '1;
    w.kind = ldtw_pkg::KIND_CMD;
    send_word(w);
    tick_until_idle(0);
  endtask

  task automatic test_data_frames();
    ldtw_pkg::in_word_t w;
    w = '1;
    w.kind          = ldtw_pkg::KIND_DATA;
    w.digit_address = 3'd0;
    send_word(w);
    tick_until_idle(0);
    w = '0;
    w.kind          = ldtw_pkg::KIND_DATA;
    w.digit_address = 3'd7;
    send_word(w);
    tick_until_idle(0);
  endtask

  task automatic test_digit_frames();
    ldtw_pkg::in_word_t w;
    w = '0;
    w.kind        = ldtw_pkg::KIND_DIGITS;
    w.digit_zero  = 8'hFF;
    w.digit_two   = 8'hA5;
    w.digit_three = 8'hFF;
    w.colon_on    = 1'b1;
    send_word(w);
    tick_until_idle(0);
    w = '1;
    w.kind      = ldtw_pkg::KIND_DIGITS;
    w.digit_two = 8'h00;
    w.colon_on  = 1'b0;
    send_word(w);
    tick_until_idle(0);
  endtask

  task automatic test_dropped_requests();
    send_word(random_word(ldtw_pkg::KIND_DATA));
    send_word(random_word(ldtw_pkg::KIND_CMD));
    send_word(random_word(ldtw_pkg::KIND_DATA));
    send_word(random_word(ldtw_pkg::KIND_DIGITS));
    tick_until_idle(20);
  endtask

  task automatic test_zero_wait();
    set_half_phase(8'd0);
    send_word(random_word(ldtw_pkg::KIND_CMD));
    tick_until_idle(0);
  endtask

  // slowest wait, then shortened mid transfer
  task automatic test_long_wait();
    set_half_phase(8'd255);
    send_word(random_word(ldtw_pkg::KIND_CMD));
    repeat (100) send_word(random_word(ldtw_pkg::KIND_TICK));
    set_half_phase(8'd1);
    tick_until_idle(0);
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned r;
    stop_at = words_sent + 100;
    while (words_sent < stop_at) begin
      r = $urandom_range(0, 9);
      if (r < 2) set_half_phase(8'($urandom_range(0, 3)));
      if (r == 9) repeat ($urandom_range(1, 4)) send_word(random_word(ldtw_pkg::KIND_TICK));
      send_word(random_word(random_request()));
      if (r == 3) begin
        repeat ($urandom_range(1, 60)) send_word(random_word(ldtw_pkg::KIND_TICK));
        set_half_phase(8'($urandom_range(1, 3)));
      end
      tick_until_idle(5);
    end
    // closing stretch, words back to back
    stalls_on = 1'b0;
    send_word(random_word(ldtw_pkg::KIND_CMD));
    tick_until_idle(5);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = '0;
    in_if.valid = 1'b0;
    in_if.word  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_command_frames();
    test_data_frames();
    test_digit_frames();
    test_dropped_requests();
    test_zero_wait();
    test_long_wait();
    test_random_traffic();

    hold_input();
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
